FILE: rtl/ttf_pkg.sv
// Package for the triangle tangent frame block: fixed widths, stage counts
// and the result record shared by the pipeline modules.
// Depends on nothing.
`default_nettype none
package ttf_pkg;

    // Fixed field widths
    localparam int UV_W      = 16;
    localparam int NRM_W     = 16;
    localparam int DUV_W     = 17;
    localparam int DPROD_W   = 34;
    localparam int DET_W     = 35;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 14;

    // Normalisation datapath widths
    localparam int M_W    = 30;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int NUM_W  = 45;
    localparam int Q_W    = 15;

    // Stage counts
    localparam int SETUP_LAT  = 4;
    localparam int NORM_PRE   = 4;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;
    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int NORM_LAT   = NORM_PRE + SQRT_STEPS + DIV_LAT;
    localparam int HAND_LAT   = 4;
    localparam int PIPE_LAT   = SETUP_LAT + NORM_LAT + HAND_LAT;

    // One finished result
    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    left_handed;
        logic                    frame_valid;
    } frame_t;

endpackage
`default_nettype wire

FILE: rtl/ttf_setup.sv
// Front end of the tangent frame pipeline: edges, UV deltas, determinant,
// unnormalised tangent and bitangent over four register stages.
// Depends on ttf_pkg.
`default_nettype none
module ttf_setup #(
    parameter int COORD_BITS = 16,
    parameter int VEC_W      = 35
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [47:0]             corner0_position,
    input  logic [47:0]             corner1_position,
    input  logic [47:0]             corner2_position,
    input  logic [31:0]             corner0_texcoord,
    input  logic [31:0]             corner1_texcoord,
    input  logic [31:0]             corner2_texcoord,
    output logic signed [VEC_W-1:0] tan_vec [3],
    output logic signed [VEC_W-1:0] bit_vec [3],
    output logic                    frame_ok
);

    localparam int E_W    = COORD_BITS + 1;
    localparam int PROD_W = COORD_BITS + 18;

    logic [63:0]                    pos64 [3];
    logic signed [COORD_BITS-1:0]   pc [3][3];
    logic signed [ttf_pkg::UV_W-1:0] u [3];
    logic signed [ttf_pkg::UV_W-1:0] v [3];

    logic signed [E_W-1:0]              e1_reg [3];
    logic signed [E_W-1:0]              e2_reg [3];
    logic signed [ttf_pkg::DUV_W-1:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [PROD_W-1:0]           pa_reg [3];
    logic signed [PROD_W-1:0]           pb_reg [3];
    logic signed [PROD_W-1:0]           pc_reg [3];
    logic signed [PROD_W-1:0]           pd_reg [3];
    logic signed [ttf_pkg::DPROD_W-1:0] dq0_reg, dq1_reg;

    logic signed [VEC_W-1:0]            tdiff_reg [3];
    logic signed [VEC_W-1:0]            bdiff_reg [3];
    logic                               det_neg_reg, det_zero_reg;

    logic signed [VEC_W-1:0]            t_reg [3];
    logic signed [VEC_W-1:0]            b_reg [3];
    logic                               ok_reg;

    logic signed [ttf_pkg::DET_W-1:0]   det;

    // Unpack the corners; bits above the 48-bit field read as zero.
    assign pos64[0] = {16'b0, corner0_position};
    assign pos64[1] = {16'b0, corner1_position};
    assign pos64[2] = {16'b0, corner2_position};
    assign u[0] = corner0_texcoord[15:0];
    assign v[0] = corner0_texcoord[31:16];
    assign u[1] = corner1_texcoord[15:0];
    assign v[1] = corner1_texcoord[31:16];
    assign u[2] = corner2_texcoord[15:0];
    assign v[2] = corner2_texcoord[31:16];

    for (genvar c = 0; c < 3; c++) begin : g_corner
        for (genvar i = 0; i < 3; i++) begin : g_comp
            assign pc[c][i] = pos64[c][i*COORD_BITS +: COORD_BITS];
        end
    end

    // Stage 1: edges and UV deltas.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= E_W'(pc[1][i]) - E_W'(pc[0][i]);
                e2_reg[i] <= E_W'(pc[2][i]) - E_W'(pc[0][i]);
            end
            du1_reg <= ttf_pkg::DUV_W'(u[1]) - ttf_pkg::DUV_W'(u[0]);
            dv1_reg <= ttf_pkg::DUV_W'(v[1]) - ttf_pkg::DUV_W'(v[0]);
            du2_reg <= ttf_pkg::DUV_W'(u[2]) - ttf_pkg::DUV_W'(u[0]);
            dv2_reg <= ttf_pkg::DUV_W'(v[2]) - ttf_pkg::DUV_W'(v[0]);
        end
    end

    // Stage 2: all the products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= PROD_W'(dv2_reg) * PROD_W'(e1_reg[i]);
                pb_reg[i] <= PROD_W'(dv1_reg) * PROD_W'(e2_reg[i]);
                pc_reg[i] <= PROD_W'(du1_reg) * PROD_W'(e2_reg[i]);
                pd_reg[i] <= PROD_W'(du2_reg) * PROD_W'(e1_reg[i]);
            end
            dq0_reg <= ttf_pkg::DPROD_W'(du1_reg) * ttf_pkg::DPROD_W'(dv2_reg);
            dq1_reg <= ttf_pkg::DPROD_W'(du2_reg) * ttf_pkg::DPROD_W'(dv1_reg);
        end
    end

    // Stage 3: differences and the determinant's sign.
    assign det = ttf_pkg::DET_W'(dq0_reg) - ttf_pkg::DET_W'(dq1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tdiff_reg[i] <= VEC_W'(pa_reg[i]) - VEC_W'(pb_reg[i]);
                bdiff_reg[i] <= VEC_W'(pc_reg[i]) - VEC_W'(pd_reg[i]);
            end
            det_neg_reg  <= det < 0;
            det_zero_reg <= det == '0;
        end
    end

    // Stage 4: apply the determinant's sign and flag degenerate triangles.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= det_neg_reg ? -tdiff_reg[i] : tdiff_reg[i];
                b_reg[i] <= det_neg_reg ? -bdiff_reg[i] : bdiff_reg[i];
            end
            ok_reg <= !det_zero_reg &&
                      (tdiff_reg[0] != '0 || tdiff_reg[1] != '0 || tdiff_reg[2] != '0);
        end
    end

    assign tan_vec  = t_reg;
    assign bit_vec  = b_reg;
    assign frame_ok = ok_reg;

endmodule
`default_nettype wire

FILE: rtl/ttf_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a
// sideband word carried alongside. Depends on ttf_pkg.
`default_nettype none
module ttf_isqrt #(
    parameter int SIDE_W = 93
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ttf_pkg::SUM_W-1:0]  radicand,
    input  logic [SIDE_W-1:0]          side_in,
    output logic [ttf_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int W     = ttf_pkg::SUM_W + 1;
    localparam int STEPS = ttf_pkg::SQRT_STEPS;

    logic [W-1:0]      rem_reg  [STEPS];
    logic [W-1:0]      res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [W-1:0] ONE_BIT = W'(1) << (2 * (STEPS - 1 - j));
        logic [W-1:0]      rem_in, res_in, trial;
        logic [SIDE_W-1:0] sd_in;

        if (j == 0) begin : g_first
            assign rem_in = W'(radicand);
            assign res_in = '0;
            assign sd_in  = side_in;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
            assign sd_in  = side_reg[j-1];
        end

        assign trial = res_in + ONE_BIT;

        // One step of the digit-by-digit root.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[j] <= rem_in - trial;
                    res_reg[j] <= (res_in >> 1) + ONE_BIT;
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    res_reg[j] <= res_in >> 1;
                end
                side_reg[j] <= sd_in;
            end
        end
    end

    assign root     = res_reg[STEPS-1][ttf_pkg::ROOT_W-1:0];
    assign side_out = side_reg[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/ttf_divide.sv
// Pipelined rounded division of one magnitude by the vector length, one
// quotient bit per stage, giving a signed Q1.14 component. Depends on ttf_pkg.
`default_nettype none
module ttf_divide (
    input  logic                              clk,
    input  logic                              en,
    input  logic [ttf_pkg::M_W-1:0]           mag,
    input  logic                              neg,
    input  logic [ttf_pkg::ROOT_W-1:0]        len,
    output logic signed [ttf_pkg::OUT_W-1:0]  unit
);

    localparam int STEPS = ttf_pkg::DIV_STEPS;
    localparam int NW    = ttf_pkg::NUM_W;
    localparam int QW    = ttf_pkg::Q_W;

    logic [NW-1:0]              num_reg;
    logic [ttf_pkg::ROOT_W-1:0] den0_reg;
    logic                       neg0_reg;

    logic [NW-1:0]              rem_reg [STEPS];
    logic [QW-1:0]              q_reg   [STEPS];
    logic [ttf_pkg::ROOT_W-1:0] den_reg [STEPS];
    logic                       neg_reg [STEPS];

    logic signed [ttf_pkg::OUT_W-1:0] unit_reg;
    logic signed [ttf_pkg::OUT_W-1:0] qs;

    // Numerator with half the divisor added for rounding.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= (NW'(mag) << ttf_pkg::FRAC_BITS) + NW'(len >> 1);
            den0_reg <= len;
            neg0_reg <= neg;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int K = STEPS - 1 - j;
        logic [NW-1:0]              rem_in, dsh;
        logic [QW-1:0]              q_in;
        logic [ttf_pkg::ROOT_W-1:0] den_in;
        logic                       neg_in;

        if (j == 0) begin : g_first
            assign rem_in = num_reg;
            assign q_in   = '0;
            assign den_in = den0_reg;
            assign neg_in = neg0_reg;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign den_in = den_reg[j-1];
            assign neg_in = neg_reg[j-1];
        end

        assign dsh = NW'(den_in) << K;

        // Restoring division step for quotient bit K.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= dsh)
                begin
                    rem_reg[j] <= rem_in - dsh;
                    q_reg[j]   <= {q_in[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    q_reg[j]   <= {q_in[QW-2:0], 1'b0};
                end
                den_reg[j] <= den_in;
                neg_reg[j] <= neg_in;
            end
        end
    end

    // Restore the sign; a zero vector has zero length and stays zero.
    assign qs = ttf_pkg::OUT_W'(q_reg[STEPS-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (den_reg[STEPS-1] == '0)
            begin
                unit_reg <= '0;
            end
            else
            begin
                unit_reg <= neg_reg[STEPS-1] ? -qs : qs;
            end
        end
    end

    assign unit = unit_reg;

endmodule
`default_nettype wire

FILE: rtl/ttf_norm.sv
// Vector normalisation to Q1.14: magnitudes, range scaling, sum of squares,
// square root and three dividers. Depends on ttf_pkg, ttf_isqrt, ttf_divide.
`default_nettype none
module ttf_norm #(
    parameter int VEC_W = 35
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [VEC_W-1:0]          vec  [3],
    output logic signed [ttf_pkg::OUT_W-1:0] unit [3]
);

    localparam int MW     = ttf_pkg::M_W;
    localparam int SH_MAX = VEC_W - MW;
    localparam int SH_W   = $clog2(SH_MAX + 1);
    localparam int SIDE_W = 3 * (MW + 1);

    logic [VEC_W-1:0]            mag1_reg [3];
    logic [2:0]                  neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [MW-1:0]               m2_reg [3];
    logic [MW-1:0]               m3_reg [3];
    logic [MW-1:0]               m4_reg [3];
    logic [2*MW-1:0]             sq3_reg [3];
    logic [ttf_pkg::SUM_W-1:0]   sum4_reg;

    logic [VEC_W-1:0]            orv;
    logic [SH_W-1:0]             sh;
    logic [2*MW-1:0]             sq_next [3];

    logic [SIDE_W-1:0]           side_in, side_out;
    logic [ttf_pkg::ROOT_W-1:0]  len;

    // Stage 1: magnitudes and signs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= vec[i] < 0;
                mag1_reg[i] <= (vec[i] < 0) ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
            end
        end
    end

    // Stage 2: halve until the largest magnitude is below 2^30.
    assign orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];

    always_comb
    begin
        sh = '0;
        for (int k = 0; k < SH_MAX; k++)
        begin
            if ((orv >> (MW + k)) != '0)
            begin
                sh = SH_W'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m2_reg[i] <= MW'(mag1_reg[i] >> sh);
            end
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: squares.
    for (genvar i = 0; i < 3; i++) begin : g_sq
        assign sq_next[i] = m2_reg[i] * m2_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq3_reg  <= sq_next;
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: sum of squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum4_reg <= ttf_pkg::SUM_W'(sq3_reg[0]) + ttf_pkg::SUM_W'(sq3_reg[1])
                      + ttf_pkg::SUM_W'(sq3_reg[2]);
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
        end
    end

    // Length, with the magnitudes and signs riding alongside.
    assign side_in = {neg4_reg, m4_reg[2], m4_reg[1], m4_reg[0]};

    ttf_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum4_reg),
        .side_in  (side_in),
        .root     (len),
        .side_out (side_out)
    );

    // One divider per component.
    for (genvar i = 0; i < 3; i++) begin : g_div
        ttf_divide u_divide (
            .clk  (clk),
            .en   (en),
            .mag  (side_out[i*MW +: MW]),
            .neg  (side_out[3*MW + i]),
            .len  (len),
            .unit (unit[i])
        );
    end

endmodule
`default_nettype wire

FILE: rtl/ttf_handed.sv
// Handedness test: sign of dot(cross(N, Tn), Bn) over four register stages,
// and assembly of the result record. Depends on ttf_pkg.
`default_nettype none
module ttf_handed (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [ttf_pkg::OUT_W-1:0] tn [3],
    input  logic signed [ttf_pkg::OUT_W-1:0] bn [3],
    input  logic [47:0]                      normal,
    input  logic                             frame_ok,
    output ttf_pkg::frame_t                  result
);

    localparam int OW = ttf_pkg::OUT_W;

    logic signed [ttf_pkg::NRM_W-1:0] n [3];

    logic signed [31:0] a0_reg, a1_reg, b0_reg, b1_reg, c0_reg, c1_reg;
    logic signed [32:0] cr_reg [3];
    logic signed [48:0] d_reg  [3];
    logic signed [50:0] dot;

    logic signed [OW-1:0] tn1_reg [3];
    logic signed [OW-1:0] tn2_reg [3];
    logic signed [OW-1:0] tn3_reg [3];
    logic signed [OW-1:0] bn1_reg [3];
    logic signed [OW-1:0] bn2_reg [3];
    logic                 ok1_reg, ok2_reg, ok3_reg;

    ttf_pkg::frame_t res_reg;

    assign n[0] = normal[15:0];
    assign n[1] = normal[31:16];
    assign n[2] = normal[47:32];

    // Stage 1: products of the normal with the tangent.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= 32'(n[1]) * 32'(tn[2]);
            a1_reg  <= 32'(n[2]) * 32'(tn[1]);
            b0_reg  <= 32'(n[2]) * 32'(tn[0]);
            b1_reg  <= 32'(n[0]) * 32'(tn[2]);
            c0_reg  <= 32'(n[0]) * 32'(tn[1]);
            c1_reg  <= 32'(n[1]) * 32'(tn[0]);
            tn1_reg <= tn;
            bn1_reg <= bn;
            ok1_reg <= frame_ok;
        end
    end

    // Stage 2: cross product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[0] <= 33'(a0_reg) - 33'(a1_reg);
            cr_reg[1] <= 33'(b0_reg) - 33'(b1_reg);
            cr_reg[2] <= 33'(c0_reg) - 33'(c1_reg);
            tn2_reg   <= tn1_reg;
            bn2_reg   <= bn1_reg;
            ok2_reg   <= ok1_reg;
        end
    end

    // Stage 3: products with the bitangent.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= 49'(cr_reg[i]) * 49'(bn2_reg[i]);
            end
            tn3_reg <= tn2_reg;
            ok3_reg <= ok2_reg;
        end
    end

    // Stage 4: dot product sign and the result; degenerate frames read zero.
    assign dot = 51'(d_reg[0]) + 51'(d_reg[1]) + 51'(d_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.tangent_x   <= ok3_reg ? tn3_reg[0] : '0;
            res_reg.tangent_y   <= ok3_reg ? tn3_reg[1] : '0;
            res_reg.tangent_z   <= ok3_reg ? tn3_reg[2] : '0;
            res_reg.left_handed <= ok3_reg && (dot < 0);
            res_reg.frame_valid <= ok3_reg;
        end
    end

    assign result = res_reg;

endmodule
`default_nettype wire

FILE: rtl/triangle_tangent_frame.sv
// Top level of the per-triangle tangent frame pipeline with its output skid.
// Depends on ttf_pkg, ttf_setup, ttf_norm and ttf_handed.
//
// Usage
//   One request on the input channel (in_valid/in_ready) carries a whole
//   triangle: three packed positions, three packed texture coordinates and
//   the normal of corner 0. One request on the output channel
//   (out_valid/out_ready) carries the unit tangent in Q1.14, the handedness
//   flag and frame_valid, which is low for a zero UV determinant or a zero
//   tangent; the tangent and handedness then read zero.
//   The delay from acceptance to out_valid is set by the 31-stage
//   square root and the 17-stage dividers of the normalisation. Throughput
//   is one triangle per cycle while the receiver takes results.
//   A skid register behind the last stage holds one result when the receiver
//   stalls; the pipeline then freezes and in_ready drops until the held
//   result is taken. Nothing is lost or repeated.
//   Reset clears the valid bits and the skid flag; in_ready is high right
//   after reset.
`default_nettype none
module triangle_tangent_frame #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [47:0]                      corner0_position,
    input  logic [47:0]                      corner1_position,
    input  logic [47:0]                      corner2_position,
    input  logic [31:0]                      corner0_texcoord,
    input  logic [31:0]                      corner1_texcoord,
    input  logic [31:0]                      corner2_texcoord,
    input  logic [47:0]                      corner0_normal,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [ttf_pkg::OUT_W-1:0] tangent_x,
    output logic signed [ttf_pkg::OUT_W-1:0] tangent_y,
    output logic signed [ttf_pkg::OUT_W-1:0] tangent_z,
    output logic                             left_handed,
    output logic                             frame_valid
);

    localparam int VEC_W   = COORD_BITS + 19;
    localparam int LAT     = ttf_pkg::PIPE_LAT;
    localparam int NRM_DLY = ttf_pkg::SETUP_LAT + ttf_pkg::NORM_LAT;
    localparam int OK_DLY  = ttf_pkg::NORM_LAT;

    logic en;

    logic [LAT-1:0]    valid_reg;
    logic [47:0]       nrm_dly_reg [NRM_DLY];
    logic [OK_DLY-1:0] ok_dly_reg;

    logic signed [VEC_W-1:0]          tan_vec [3];
    logic signed [VEC_W-1:0]          bit_vec [3];
    logic                             frame_ok;
    logic signed [ttf_pkg::OUT_W-1:0] tn [3];
    logic signed [ttf_pkg::OUT_W-1:0] bn [3];

    ttf_pkg::frame_t pipe_res;
    ttf_pkg::frame_t skid_reg;
    ttf_pkg::frame_t out_res;
    logic            skid_full_reg;
    logic            last_valid;

    // The whole pipeline moves whenever the skid register is free.
    assign en       = !skid_full_reg;
    assign in_ready = en;

    ttf_setup #(
        .COORD_BITS (COORD_BITS),
        .VEC_W      (VEC_W)
    ) u_setup (
        .clk              (clk),
        .en               (en),
        .corner0_position (corner0_position),
        .corner1_position (corner1_position),
        .corner2_position (corner2_position),
        .corner0_texcoord (corner0_texcoord),
        .corner1_texcoord (corner1_texcoord),
        .corner2_texcoord (corner2_texcoord),
        .tan_vec          (tan_vec),
        .bit_vec          (bit_vec),
        .frame_ok         (frame_ok)
    );

    ttf_norm #(
        .VEC_W (VEC_W)
    ) u_norm_tan (
        .clk  (clk),
        .en   (en),
        .vec  (tan_vec),
        .unit (tn)
    );

    ttf_norm #(
        .VEC_W (VEC_W)
    ) u_norm_bit (
        .clk  (clk),
        .en   (en),
        .vec  (bit_vec),
        .unit (bn)
    );

    // Normal and degenerate flag wait for the normalised vectors.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_dly_reg[0] <= corner0_normal;
            for (int i = 1; i < NRM_DLY; i++)
            begin
                nrm_dly_reg[i] <= nrm_dly_reg[i-1];
            end
            ok_dly_reg <= {ok_dly_reg[OK_DLY-2:0], frame_ok};
        end
    end

    ttf_handed u_handed (
        .clk      (clk),
        .en       (en),
        .tn       (tn),
        .bn       (bn),
        .normal   (nrm_dly_reg[NRM_DLY-1]),
        .frame_ok (ok_dly_reg[OK_DLY-1]),
        .result   (pipe_res)
    );

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    assign last_valid = valid_reg[LAT-1];

    // Skid flag: set when a result is not taken, cleared when the held one is.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (last_valid && !out_ready)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    // Skid payload.
    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && last_valid && !out_ready)
        begin
            skid_reg <= pipe_res;
        end
    end

    // Output selection.
    assign out_res     = skid_full_reg ? skid_reg : pipe_res;
    assign out_valid   = skid_full_reg || last_valid;
    assign tangent_x   = out_res.tangent_x;
    assign tangent_y   = out_res.tangent_y;
    assign tangent_z   = out_res.tangent_z;
    assign left_handed = out_res.left_handed;
    assign frame_valid = out_res.frame_valid;

endmodule
`default_nettype wire

FILE: rtl/ttf_checker.sv
// Port-level checks for the tangent frame block, bound to the top level.
// Depends on triangle_tangent_frame's ports only.
`default_nettype none
module ttf_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] tangent_x,
    input  logic signed [15:0] tangent_y,
    input  logic signed [15:0] tangent_z,
    input  logic               left_handed,
    input  logic               frame_valid
);

    // A stalled result request is still offered in the next cycle.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request withdrawn while stalled");

    // A degenerate frame carries a zero tangent and positive handedness.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |->
            tangent_x == 0 && tangent_y == 0 && tangent_z == 0 && !left_handed)
        else $error("degenerate frame with non-zero payload");

    // A valid tangent stays within unit range.
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |->
            tangent_x <= 16384 && tangent_x >= -16384 &&
            tangent_y <= 16384 && tangent_y >= -16384 &&
            tangent_z <= 16384 && tangent_z >= -16384)
        else $error("tangent component out of unit range");

    // Input back-pressure only while a result is waiting.
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // A stalled result keeps its flags.
    a_flags_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(frame_valid) && $stable(left_handed))
        else $error("result flags changed while stalled");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (.*);
`default_nettype wire
